/* sv/scvm_pkg.sv */
package scvm_pkg;

  // field widths
  localparam int VOL_W  = 9;
  localparam int PAN_W  = 9;
  localparam int MVOL_W = 7;
  localparam int MPAN_W = 8;
  localparam int BAL_W  = 8;
  localparam int GAIN_W = 8;
  localparam int OUT_W  = 7;
  localparam int CFG_W  = 8;
  localparam int IDX_W  = 2;

  // arithmetic constants
  localparam int PAN_FULL   = 128;
  localparam int PAN_MID    = 32;
  localparam int GAIN_UNITY = 64;
  localparam int SAT_LIMIT  = 4096;
  localparam int ROUND_HALF = 32;

  // register indexes
  localparam logic [IDX_W-1:0] REG_MASTER_VOLUME  = 2'd0;
  localparam logic [IDX_W-1:0] REG_MASTER_PAN     = 2'd1;
  localparam logic [IDX_W-1:0] REG_MASTER_BALANCE = 2'd2;

  // register reset values
  localparam logic [MVOL_W-1:0] MVOL_RESET = 7'd64;
  localparam logic [MPAN_W-1:0] MPAN_RESET = 8'd64;
  localparam logic [BAL_W-1:0]  BAL_RESET  = 8'd0;

  // per-stage advance strobes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

endpackage

/* sv/scvm_pan_split.sv */
module scvm_pan_split (
  input  logic                                clk,
  input  scvm_pkg::stage_en_t                 en,
  input  logic        [scvm_pkg::VOL_W-1:0]   channel_volume,
  input  logic signed [scvm_pkg::PAN_W-1:0]   channel_pan,
  output logic        [scvm_pkg::GAIN_W-1:0]  g0,
  output logic        [scvm_pkg::GAIN_W-1:0]  g1
);

  logic signed [scvm_pkg::PAN_W:0]   pan_ext;
  logic signed [scvm_pkg::PAN_W:0]   pan_k;
  logic signed [20:0]                pan_prod;
  logic        [scvm_pkg::GAIN_W-1:0] far_gain;
  logic        [scvm_pkg::VOL_W-3:0]  vol_q;
  logic                              pan_neg;
  logic        [scvm_pkg::GAIN_W-1:0] near_gain;

  // stage 1: far gain product, volume*(128-|pan|), floor >>10, low 8 bits
  assign pan_ext = {channel_pan[scvm_pkg::PAN_W-1], channel_pan};
  assign pan_k   = channel_pan[scvm_pkg::PAN_W-1]
                 ? ($signed(10'(scvm_pkg::PAN_FULL)) + pan_ext)
                 : ($signed(10'(scvm_pkg::PAN_FULL)) - pan_ext);
  assign pan_prod = $signed({2'b00, channel_volume}) * pan_k;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      far_gain <= pan_prod[17:10];
      vol_q    <= channel_volume[scvm_pkg::VOL_W-1:2];
      pan_neg  <= channel_pan[scvm_pkg::PAN_W-1];
    end
  end

  // stage 2: near side takes the remainder, then steer to left/right
  assign near_gain = {1'b0, vol_q} - far_gain;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      g0 <= pan_neg ? near_gain : far_gain;
      g1 <= pan_neg ? far_gain : near_gain;
    end
  end

endmodule

/* sv/scvm_matrix.sv */
module scvm_matrix (
  input  logic                                clk,
  input  scvm_pkg::stage_en_t                 en,
  input  logic        [scvm_pkg::MVOL_W-1:0]  master_volume,
  input  logic signed [scvm_pkg::MPAN_W-1:0]  master_pan,
  input  logic signed [scvm_pkg::BAL_W-1:0]   master_balance,
  output logic        [7:0]                   m00,
  output logic        [7:0]                   m01,
  output logic        [7:0]                   m10,
  output logic        [7:0]                   m11
);

  logic signed [7:0]  half_pan;
  logic signed [7:0]  ent_a;
  logic signed [7:0]  ent_b;
  logic               bal_pos;
  logic signed [7:0]  bal_gain;
  logic signed [15:0] af_prod;
  logic signed [15:0] bf_prod;

  logic signed [15:0] af_q;
  logic signed [15:0] bf_q;
  logic signed [7:0]  a_q;
  logic signed [7:0]  b_q;
  logic               bal_pos_q;
  logic [scvm_pkg::MVOL_W-1:0] mvol_q1;
  logic [scvm_pkg::MVOL_W-1:0] mvol_q2;

  logic signed [7:0]  sa;
  logic signed [7:0]  sb;
  logic signed [7:0]  r00;
  logic signed [7:0]  r01;
  logic signed [7:0]  r10;
  logic signed [7:0]  r11;
  logic signed [7:0]  mvol_s;
  logic signed [15:0] p00;
  logic signed [15:0] p01;
  logic signed [15:0] p10;
  logic signed [15:0] p11;

  // stage 1: pan entries and balance scaling product
  assign half_pan = master_pan >>> 1;
  assign ent_a    = 8'(scvm_pkg::PAN_MID) + half_pan;
  assign ent_b    = 8'(scvm_pkg::PAN_MID) - half_pan;
  assign bal_pos  = !master_balance[scvm_pkg::BAL_W-1] && (master_balance != '0);
  assign bal_gain = bal_pos ? (8'(scvm_pkg::GAIN_UNITY) - master_balance)
                            : (8'(scvm_pkg::GAIN_UNITY) + master_balance);
  assign af_prod  = ent_a * bal_gain;
  assign bf_prod  = ent_b * bal_gain;

  always_ff @(posedge clk) begin
    if (en.s1) begin
      af_q      <= af_prod;
      bf_q      <= bf_prod;
      a_q       <= ent_a;
      b_q       <= ent_b;
      bal_pos_q <= bal_pos;
      mvol_q1   <= master_volume;
    end
  end

  // stage 2: apply balance to one row (floor >>6, wrap to 8 bits)
  assign sa = af_q[13:6];
  assign sb = bf_q[13:6];

  always_ff @(posedge clk) begin
    if (en.s2) begin
      r00     <= bal_pos_q ? sa : a_q;
      r01     <= bal_pos_q ? sb : b_q;
      r10     <= bal_pos_q ? b_q : sb;
      r11     <= bal_pos_q ? a_q : sa;
      mvol_q2 <= mvol_q1;
    end
  end

  // stage 3: master volume on every entry
  assign mvol_s = $signed({1'b0, mvol_q2});
  assign p00 = r00 * mvol_s;
  assign p01 = r01 * mvol_s;
  assign p10 = r10 * mvol_s;
  assign p11 = r11 * mvol_s;

  always_ff @(posedge clk) begin
    if (en.s3) begin
      m00 <= p00[13:6];
      m01 <= p01[13:6];
      m10 <= p10[13:6];
      m11 <= p11[13:6];
    end
  end

endmodule

/* sv/scvm_mix.sv */
module scvm_mix (
  input  logic                                clk,
  input  scvm_pkg::stage_en_t                 en,
  input  logic [scvm_pkg::GAIN_W-1:0]         g0,
  input  logic [scvm_pkg::GAIN_W-1:0]         g1,
  input  logic [7:0]                          m00,
  input  logic [7:0]                          m01,
  input  logic [7:0]                          m10,
  input  logic [7:0]                          m11,
  output logic [scvm_pkg::OUT_W-1:0]          left_volume,
  output logic [scvm_pkg::OUT_W-1:0]          right_volume
);

  logic [scvm_pkg::GAIN_W-1:0] g0_q;
  logic [scvm_pkg::GAIN_W-1:0] g1_q;
  logic [15:0] p00;
  logic [15:0] p01;
  logic [15:0] p10;
  logic [15:0] p11;
  logic [16:0] sum_l;
  logic [16:0] sum_r;
  logic [16:0] rnd_l;
  logic [16:0] rnd_r;

  // stage 3: line the gains up with the matrix entries
  always_ff @(posedge clk) begin
    if (en.s3) begin
      g0_q <= g0;
      g1_q <= g1;
    end
  end

  // stage 4: four gain products
  always_ff @(posedge clk) begin
    if (en.s4) begin
      p00 <= m00 * g0_q;
      p01 <= m01 * g1_q;
      p10 <= m10 * g0_q;
      p11 <= m11 * g1_q;
    end
  end

  // stage 5: sum, round and saturate
  assign sum_l = {1'b0, p00} + {1'b0, p01};
  assign sum_r = {1'b0, p10} + {1'b0, p11};
  assign rnd_l = sum_l + 17'(scvm_pkg::ROUND_HALF);
  assign rnd_r = sum_r + 17'(scvm_pkg::ROUND_HALF);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      left_volume  <= (sum_l > 17'(scvm_pkg::SAT_LIMIT)) ?
                      7'(scvm_pkg::GAIN_UNITY) : rnd_l[12:6];
      right_volume <= (sum_r > 17'(scvm_pkg::SAT_LIMIT)) ?
                      7'(scvm_pkg::GAIN_UNITY) : rnd_r[12:6];
    end
  end

endmodule

/* sv/stereo_channel_volume_matrix_unit.sv */
// channel | signals                                   | direction
// --------+-------------------------------------------+----------
// in      | in_valid, in_ready, channel_volume/pan    | into block
// out     | out_valid, out_ready, left/right_volume   | out of block
// cfg     | cfg_we, cfg_index, cfg_data               | into block
//
// Five-stage pipeline; a word is accepted every cycle unless every stage is
// full and the output is stalled. The stage count is set by the multiply
// chain: pan gain, balance row, master volume, gain products, then sum and
// saturate. Reset clears the stage valid bits and loads the master registers.
// A stalled output holds its word; each stage keeps its own valid bit, so
// empty stages still fill while the output waits.
module stereo_channel_volume_matrix_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [scvm_pkg::VOL_W-1:0]   channel_volume,
  input  logic signed [scvm_pkg::PAN_W-1:0]   channel_pan,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic        [scvm_pkg::OUT_W-1:0]   left_volume,
  output logic        [scvm_pkg::OUT_W-1:0]   right_volume,
  input  logic                                cfg_we,
  input  logic        [scvm_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [scvm_pkg::CFG_W-1:0]   cfg_data
);

  logic        [scvm_pkg::MVOL_W-1:0] master_volume;
  logic signed [scvm_pkg::MPAN_W-1:0] master_pan;
  logic signed [scvm_pkg::BAL_W-1:0]  master_balance;

  logic [4:0]            stage_valid;
  scvm_pkg::stage_en_t   en;

  logic [scvm_pkg::GAIN_W-1:0] g0;
  logic [scvm_pkg::GAIN_W-1:0] g1;
  logic [7:0] m00;
  logic [7:0] m01;
  logic [7:0] m10;
  logic [7:0] m11;

  // master registers
  always_ff @(posedge clk) begin
    if (rst) begin
      master_volume  <= scvm_pkg::MVOL_RESET;
      master_pan     <= scvm_pkg::MPAN_RESET;
      master_balance <= scvm_pkg::BAL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        scvm_pkg::REG_MASTER_VOLUME:  master_volume  <= cfg_data[scvm_pkg::MVOL_W-1:0];
        scvm_pkg::REG_MASTER_PAN:     master_pan     <= cfg_data[scvm_pkg::MPAN_W-1:0];
        scvm_pkg::REG_MASTER_BALANCE: master_balance <= cfg_data[scvm_pkg::BAL_W-1:0];
        default: ;
      endcase
    end
  end

  // stage advance: a stage moves when empty or when the next one moves
  assign en.s5 = !stage_valid[4] || out_ready;
  assign en.s4 = !stage_valid[3] || en.s5;
  assign en.s3 = !stage_valid[2] || en.s4;
  assign en.s2 = !stage_valid[1] || en.s3;
  assign en.s1 = !stage_valid[0] || en.s2;

  assign in_ready  = en.s1;
  assign out_valid = stage_valid[4];

  // valid bits travel with the words
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      if (en.s1) stage_valid[0] <= in_valid;
      if (en.s2) stage_valid[1] <= stage_valid[0];
      if (en.s3) stage_valid[2] <= stage_valid[1];
      if (en.s4) stage_valid[3] <= stage_valid[2];
      if (en.s5) stage_valid[4] <= stage_valid[3];
    end
  end

  scvm_pan_split u_pan (
    .clk            (clk),
    .en             (en),
    .channel_volume (channel_volume),
    .channel_pan    (channel_pan),
    .g0             (g0),
    .g1             (g1)
  );

  scvm_matrix u_matrix (
    .clk            (clk),
    .en             (en),
    .master_volume  (master_volume),
    .master_pan     (master_pan),
    .master_balance (master_balance),
    .m00            (m00),
    .m01            (m01),
    .m10            (m10),
    .m11            (m11)
  );

  scvm_mix u_mix (
    .clk          (clk),
    .en           (en),
    .g0           (g0),
    .g1           (g1),
    .m00          (m00),
    .m01          (m01),
    .m10          (m10),
    .m11          (m11),
    .left_volume  (left_volume),
    .right_volume (right_volume)
  );

  // saturation bounds both gains at unity
  a_out_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (left_volume <= 7'(scvm_pkg::GAIN_UNITY)) &&
                  (right_volume <= 7'(scvm_pkg::GAIN_UNITY)))
    else $error("output gain above unity");

  // an accepted word occupies the first stage next cycle
  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> stage_valid[0])
    else $error("accepted word lost at stage 1");

  // back-pressure reaches the input only when every stage is full
  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (stage_valid == 5'b11111) && !out_ready)
    else $error("input stalled with a free stage");

  // a held stage-4 word means the output is stuck
  a_hold4: assert property (@(posedge clk) disable iff (rst)
    (stage_valid[3] && !en.s4) |-> (stage_valid[4] && !out_ready))
    else $error("stage 4 held without output stall");

endmodule
